/* hw/rtl/pna_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pna_pkg
// types and constants shared by the padded number to ascii unit
// ----------------------------------------------------------------------------
package pna_pkg;

  // request as it arrives on the input channel
  typedef struct packed {
    logic        mode;
    logic [15:0] value;
    logic [2:0]  pad_width;
    logic [7:0]  pad_char;
  } req_t;

  // one character on the output channel
  typedef struct packed {
    logic [7:0] char_out;
    logic       last;
  } res_t;

  // classified request held in the queue
  typedef struct packed {
    logic        hex;
    logic [15:0] value;
    logic [2:0]  width;
    logic [7:0]  pad_char;
  } job_t;

  localparam logic       MODE_DEC = 1'b0;
  localparam logic       MODE_HEX = 1'b1;

  localparam logic [2:0] DEC_CAP = 3'd5;
  localparam logic [2:0] HEX_CAP = 3'd4;
  localparam int         BUF_DEPTH = 5;

  localparam logic [7:0] ASCII_ZERO = 8'h30;
  localparam logic [7:0] ASCII_A    = 8'h41;

  // reciprocal of ten, exact for 16-bit operands with a shift of 19
  localparam logic [15:0] RECIP_TEN = 16'd52429;
  localparam int          RECIP_SHIFT = 19;

  function automatic logic [7:0] digit_ascii(input logic [3:0] d);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = ASCII_ZERO + {4'b0, d};
    end else begin
      c = ASCII_A + {4'b0, d - 4'd10};
    end
    return c;
  endfunction

endpackage

/* hw/rtl/pna_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pna_front
// accepts requests and classifies them: picks the cap, clips the pad width
// ----------------------------------------------------------------------------
module pna_front (
  input  logic          req_valid,
  output logic          req_ready,
  input  pna_pkg::req_t req,
  input  logic          q_full,
  output logic          push,
  output pna_pkg::job_t job
);

  logic [2:0] cap;

  assign req_ready = !q_full;
  assign push      = req_valid && !q_full;

  assign cap = (req.mode == pna_pkg::MODE_HEX) ? pna_pkg::HEX_CAP : pna_pkg::DEC_CAP;

  always_comb begin
    job.hex      = (req.mode == pna_pkg::MODE_HEX);
    job.value    = req.value;
    job.width    = (req.pad_width > cap) ? cap : req.pad_width;
    job.pad_char = req.pad_char;
  end

endmodule

/* hw/rtl/pna_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pna_queue
// two-entry queue of classified requests between front and back
// ----------------------------------------------------------------------------
module pna_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  pna_pkg::job_t wr_job,
  input  logic          pop,
  output pna_pkg::job_t rd_job,
  output logic          full,
  output logic          empty
);

  pna_pkg::job_t slot [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;

  assign full   = (count == 2'd2);
  assign empty  = (count == 2'd0);
  assign rd_job = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* hw/rtl/pna_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pna_back
// converts one request into digits, then sends the padded characters
// ----------------------------------------------------------------------------
module pna_back #(
  parameter int VAL_W = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_empty,
  input  pna_pkg::job_t job,
  output logic          pop,
  output logic          res_valid,
  input  logic          res_ready,
  output pna_pkg::res_t res
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]       state;
  logic [VAL_W-1:0] v;
  logic             hex;
  logic [2:0]       width;
  logic [7:0]       pad;
  logic [2:0]       idx;
  logic [2:0]       ndig;
  logic [2:0]       pos;
  logic [3:0]       dig [pna_pkg::BUF_DEPTH];

  logic [2:0]        cap;
  logic [VAL_W+15:0] prod;
  logic [VAL_W-1:0]  quot;
  logic [VAL_W-1:0]  quot10;
  logic [3:0]        digit;
  logic [VAL_W-1:0]  v_next;
  logic [2:0]        cnt;
  logic [2:0]        len;
  logic [2:0]        start_pos;
  logic              slot_free;

  assign cap = hex ? pna_pkg::HEX_CAP : pna_pkg::DEC_CAP;

  // divide by ten through the reciprocal
  assign prod   = {16'b0, v} * {{VAL_W{1'b0}}, pna_pkg::RECIP_TEN};
  assign quot   = VAL_W'(prod >> pna_pkg::RECIP_SHIFT);
  assign quot10 = (quot << 3) + (quot << 1);

  assign digit  = hex ? v[3:0] : 4'(v - quot10);
  assign v_next = hex ? (v >> 4) : quot;

  assign cnt       = idx + 3'd1;
  assign len       = (width > cnt) ? width : cnt;
  assign start_pos = cap - len;

  assign pop       = (state == ST_IDLE) && !q_empty;
  assign slot_free = !res_valid || res_ready;

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (!q_empty) begin
          v     <= job.value[VAL_W-1:0];
          hex   <= job.hex;
          width <= job.width;
          pad   <= job.pad_char;
        end
      end
      ST_CONV: begin
        dig[cap - 3'd1 - idx] <= digit;
        v                     <= v_next;
        ndig                  <= cnt;
        pos                   <= start_pos;
      end
      ST_EMIT: begin
        if (slot_free) begin
          res.char_out <= (pos >= cap - ndig) ? pna_pkg::digit_ascii(dig[pos]) : pad;
          res.last     <= (pos == cap - 3'd1);
          pos          <= pos + 3'd1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      idx       <= 3'd0;
      res_valid <= 1'b0;
    end else begin
      // a new character loads, or the waiting one holds until taken
      res_valid <= ((state == ST_EMIT) && slot_free) || (res_valid && !res_ready);
      unique case (state)
        ST_IDLE: begin
          idx <= 3'd0;
          if (!q_empty) begin
            state <= ST_CONV;
          end
        end
        ST_CONV: begin
          idx <= cnt;
          if (v_next == '0 || idx == cap - 3'd1) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (slot_free) begin
            if (pos == cap - 3'd1) begin
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

/* hw/rtl/padded_number_to_ascii_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// padded_number_to_ascii_unit
// formats an unsigned number as padded decimal or upper-case hex ascii
// ----------------------------------------------------------------------------
// usage
//   request channel (req_valid / req_ready / req): one transfer per number,
//   carrying mode, value, pad_width and pad_char
//   result channel (res_valid / res_ready / res): one transfer per character,
//   most significant first, pad characters before digits, last on the final one
//   a number gives one to five characters (cap of five decimal, four hex)
// timing
//   the sequencer loads a request from the queue, then the digit loop runs
//   once per significant digit (one divide by ten or nibble shift per
//   cycle), then each character goes into the single output register,
//   which holds it while res_ready is low
//   a two-entry queue lets up to two requests wait while one is converted
// reset
//   rst clears the queue, the sequencer and the output valid
// stall
//   while res_ready is low the character holds in the output register, the
//   back end waits, and requests keep filling the queue until it is full
// ----------------------------------------------------------------------------
module padded_number_to_ascii_unit #(
  parameter int VALUE_BITS = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  pna_pkg::req_t req,
  output logic          res_valid,
  input  logic          res_ready,
  output pna_pkg::res_t res
);

  // only the low bits of value take part, never more than the 16 carried
  localparam int VAL_W = (VALUE_BITS < 16) ? VALUE_BITS : 16;

  logic          push;
  logic          pop;
  logic          q_full;
  logic          q_empty;
  pna_pkg::job_t wr_job;
  pna_pkg::job_t rd_job;

  // front: classify and push into the queue
  pna_front u_front (
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .q_full    (q_full),
    .push      (push),
    .job       (wr_job)
  );

  // queue that decouples acceptance from conversion
  pna_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_job (wr_job),
    .pop    (pop),
    .rd_job (rd_job),
    .full   (q_full),
    .empty  (q_empty)
  );

  // back: digit loop and character sender
  pna_back #(
    .VAL_W (VAL_W)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .job       (rd_job),
    .pop       (pop),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

endmodule
